>>> hdl/dual_seed_xxhash64_engine_assert.svh
// assertion macros used by the dual-seed xxhash64 checker
`ifndef DUAL_SEED_XXHASH64_ENGINE_ASSERT_SVH
`define DUAL_SEED_XXHASH64_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DSXE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define DSXE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/dsxe_pkg.sv
// shared types, constants and helpers of the dual-seed xxhash64 engine
package dsxe_pkg;

	// xxhash64 primes
	localparam logic [63:0] P1 = 64'd11400714785074694791;
	localparam logic [63:0] P2 = 64'd14029467366897019727;
	localparam logic [63:0] P3 = 64'd1609587929392839161;
	localparam logic [63:0] P4 = 64'd9650029242287828579;
	localparam logic [63:0] P5 = 64'd2870177450012600261;

	// configuration map: register index is paddr[3]
	localparam int ADDR_W = 4;
	localparam logic REG_SEED_LOW = 1'b0;
	localparam logic REG_SEED_HIGH = 1'b1;

	// queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// item classes produced by the front end
	typedef enum logic [1:0] {
		KIND_BUF = 2'd0,
		KIND_STRIPE = 2'd1,
		KIND_FINAL = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t kind;
		logic [63:0] word;
		logic [1:0] slot;
		logic absorb;
		logic [1:0] nwords;
		logic [3:0] nbytes;
		logic [63:0] len;
	} item_t;

	// back-end work phases
	typedef enum logic [2:0] {
		PH_STRIPE = 3'd0,
		PH_MERGE = 3'd1,
		PH_WORDS = 3'd2,
		PH_TAIL8 = 3'd3,
		PH_TAIL4 = 3'd4,
		PH_TAIL1 = 3'd5,
		PH_AVAL = 3'd6
	} phase_t;

	typedef struct packed {
		logic start;
		logic [63:0] a;
		logic [63:0] c;
	} mul_req_t;

	typedef struct packed {
		logic done;
		logic [63:0] p;
	} mul_rsp_t;

	// rotate left by a constant amount (1..63)
	function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
		return (x << r) | (x >> (64 - r));
	endfunction

	// next tail step given words folded so far and bytes left
	function automatic phase_t pick_phase(input logic [1:0] k, input logic [1:0] nw,
			input logic [3:0] n);
		phase_t ph;
		priority if (k < nw) begin
			ph = PH_WORDS;
		end else if (n >= 4'd8) begin
			ph = PH_TAIL8;
		end else if (n >= 4'd4) begin
			ph = PH_TAIL4;
		end else if (n != 4'd0) begin
			ph = PH_TAIL1;
		end else begin
			ph = PH_AVAL;
		end
		return ph;
	endfunction

endpackage

>>> hdl/dsxe_front.sv
// front end: accepts words, tracks length and stripe position, classifies items
module dsxe_front import dsxe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic word_valid,
	output logic word_ready,
	input logic [63:0] data_word,
	input logic [3:0] valid_bytes,
	input logic last,
	input logic full,
	output logic push,
	output item_t item
);

	logic [1:0] pc_q;
	logic [63:0] len_q;
	logic [3:0] nb;
	logic [63:0] masked;
	logic [63:0] len_sum;

	assign word_ready = !full;
	assign push = word_valid && !full;

	// clamp byte count and mask unused bytes
	always_comb begin
		if (last) begin
			nb = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
		end else begin
			nb = 4'd8;
		end
		for (int b = 0; b < 8; b++) begin
			masked[8*b +: 8] = (4'(b) < nb) ? data_word[8*b +: 8] : 8'h00;
		end
		len_sum = len_q + 64'(nb);
	end

	// classify the item
	always_comb begin
		item.kind = KIND_BUF;
		item.word = masked;
		item.slot = pc_q;
		item.absorb = 1'b0;
		item.nwords = pc_q;
		item.nbytes = nb;
		item.len = len_sum;
		if (!last) begin
			if (pc_q == 2'd3) begin
				item.kind = KIND_STRIPE;
			end
		end else begin
			item.kind = KIND_FINAL;
			if (nb == 4'd8 && pc_q == 2'd3) begin
				item.absorb = 1'b1;
				item.nwords = 2'd0;
				item.nbytes = 4'd0;
			end
		end
	end

	// message position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= 2'd0;
			len_q <= 64'd0;
		end else if (push) begin
			if (last) begin
				pc_q <= 2'd0;
				len_q <= 64'd0;
			end else begin
				pc_q <= pc_q + 2'd1;
				len_q <= len_sum;
			end
		end
	end

endmodule

>>> hdl/dsxe_fifo.sv
// short item queue between front end and back end
module dsxe_fifo import dsxe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input item_t din,
	output logic full,
	input logic pop,
	output logic not_empty,
	output item_t dout
);

	item_t mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

>>> hdl/dsxe_mul.sv
// 64x64 low-half multiplier built from one 32x32 multiplier, one partial product at a time
module dsxe_mul import dsxe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mul_req_t req,
	output mul_rsp_t rsp
);

	logic busy_q;
	logic [1:0] ph_q;
	logic done_q;
	logic [63:0] a_q;
	logic [63:0] c_q;
	logic [63:0] acc_q;
	logic [31:0] ma;
	logic [31:0] mb;
	logic [63:0] prod;
	logic [63:0] sum;

	// partial product: lo*lo, then hi*lo and lo*hi shifted up
	always_comb begin
		ma = (ph_q == 2'd1) ? a_q[63:32] : a_q[31:0];
		mb = (ph_q == 2'd2) ? c_q[63:32] : c_q[31:0];
		prod = 64'(ma) * 64'(mb);
		sum = (ph_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'h0};
	end

	assign rsp.done = done_q;
	assign rsp.p = acc_q;

	// operands and running sum
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			c_q <= req.c;
		end else if (busy_q) begin
			acc_q <= sum;
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				ph_q <= 2'd0;
			end else if (busy_q) begin
				if (ph_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					ph_q <= ph_q + 2'd1;
				end
			end
		end
	end

endmodule

>>> hdl/dsxe_back.sv
// back end: stripe absorb, convergence, tail fold and avalanche for both seeds
module dsxe_back import dsxe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [63:0] seed_low,
	input logic [63:0] seed_high,
	input logic q_valid,
	input item_t q_item,
	output logic q_pop,
	output mul_req_t mreq,
	input mul_rsp_t mrsp,
	output logic digest_valid,
	input logic digest_ready,
	output logic [63:0] digest_low,
	output logic [63:0] digest_high
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_START = 5'b00010,
		S_ISSUE = 5'b00100,
		S_WAIT = 5'b01000,
		S_OUT = 5'b10000
	} bstate_t;

	bstate_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic [1:0] jstep_q, jstep_d;
	logic [1:0] k_q, k_d;
	logic lane_q, lane_d;
	logic seen_q, seen_d;
	logic ovalid_q, ovalid_d;

	logic [63:0] acc_q [8];
	logic [63:0] acc_d [8];
	logic [63:0] pw_q [3];
	logic [63:0] pw_d [3];
	item_t it_q, it_d;
	logic [63:0] h_q, h_d;
	logic [63:0] t_q, t_d;
	logic [63:0] tw_q, tw_d;
	logic [3:0] tn_q, tn_d;
	logic [63:0] dig0_q, dig0_d;
	logic [63:0] dlow_q, dlow_d;
	logic [63:0] dhigh_q, dhigh_d;

	logic [63:0] acc_sel;
	logic [63:0] wsel;
	logic [63:0] seed_lane;
	logic [63:0] conv0;
	logic [63:0] conv1;
	logic [63:0] conv_sel;
	logic [63:0] p;
	logic [63:0] mx;
	logic [63:0] mc;

	// operand selection
	always_comb begin
		acc_sel = acc_q[{lane_q, k_q}];
		unique case (k_q)
			2'd0: wsel = pw_q[0];
			2'd1: wsel = pw_q[1];
			2'd2: wsel = pw_q[2];
			default: wsel = it_q.word;
		endcase
		seed_lane = lane_q ? seed_high : seed_low;
		conv0 = rotl64(acc_q[0], 1) + rotl64(acc_q[1], 7) + rotl64(acc_q[2], 12)
			+ rotl64(acc_q[3], 18);
		conv1 = rotl64(acc_q[4], 1) + rotl64(acc_q[5], 7) + rotl64(acc_q[6], 12)
			+ rotl64(acc_q[7], 18);
		conv_sel = lane_q ? conv1 : conv0;
		p = mrsp.p;
	end

	// multiplier job for the current phase and step
	always_comb begin
		mx = h_q;
		mc = P1;
		unique case (phase_q)
			PH_STRIPE: begin
				if (jstep_q == 2'd0) begin
					mx = wsel;
					mc = P2;
				end else begin
					mx = t_q;
				end
			end
			PH_MERGE: begin
				if (jstep_q == 2'd0) begin
					mx = acc_sel;
					mc = P2;
				end else begin
					mx = t_q;
				end
			end
			PH_WORDS, PH_TAIL8: begin
				if (jstep_q == 2'd0) begin
					mx = (phase_q == PH_WORDS) ? wsel : tw_q;
					mc = P2;
				end else if (jstep_q == 2'd1) begin
					mx = t_q;
				end else begin
					mx = rotl64(h_q, 27);
				end
			end
			PH_TAIL4: begin
				if (jstep_q == 2'd0) begin
					mx = {32'h0, tw_q[31:0]};
				end else begin
					mx = rotl64(h_q, 23);
					mc = P2;
				end
			end
			PH_TAIL1: begin
				if (jstep_q == 2'd0) begin
					mx = {56'h0, tw_q[7:0]};
					mc = P5;
				end else begin
					mx = rotl64(h_q, 11);
				end
			end
			PH_AVAL: begin
				if (jstep_q == 2'd0) begin
					mx = h_q ^ (h_q >> 33);
					mc = P2;
				end else begin
					mx = h_q ^ (h_q >> 29);
					mc = P3;
				end
			end
			default: begin
				mx = h_q;
			end
		endcase
		mreq.start = (state_q == S_ISSUE);
		mreq.a = mx;
		mreq.c = mc;
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		jstep_d = jstep_q;
		k_d = k_q;
		lane_d = lane_q;
		seen_d = seen_q;
		ovalid_d = ovalid_q && !digest_ready;
		acc_d = acc_q;
		pw_d = pw_q;
		it_d = it_q;
		h_d = h_q;
		t_d = t_q;
		tw_d = tw_q;
		tn_d = tn_q;
		dig0_d = dig0_q;
		dlow_d = dlow_q;
		dhigh_d = dhigh_q;
		q_pop = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					it_d = q_item;
					priority if (q_item.kind == KIND_BUF) begin
						unique case (q_item.slot)
							2'd0: pw_d[0] = q_item.word;
							2'd1: pw_d[1] = q_item.word;
							default: pw_d[2] = q_item.word;
						endcase
					end else if (q_item.kind == KIND_STRIPE || q_item.absorb) begin
						// first stripe of a message loads the accumulators from the seeds
						if (!seen_q) begin
							acc_d[0] = seed_low + P1 + P2;
							acc_d[1] = seed_low + P2;
							acc_d[2] = seed_low;
							acc_d[3] = seed_low - P1;
							acc_d[4] = seed_high + P1 + P2;
							acc_d[5] = seed_high + P2;
							acc_d[6] = seed_high;
							acc_d[7] = seed_high - P1;
						end
						phase_d = PH_STRIPE;
						lane_d = 1'b0;
						k_d = 2'd0;
						jstep_d = 2'd0;
						state_d = S_ISSUE;
					end else if (q_item.kind == KIND_FINAL) begin
						lane_d = 1'b0;
						state_d = S_START;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_START: begin
				// lane start: converge or seed plus P5
				if (seen_q) begin
					h_d = conv_sel;
					phase_d = PH_MERGE;
				end else begin
					h_d = seed_lane + P5 + it_q.len;
					phase_d = pick_phase(2'd0, it_q.nwords, it_q.nbytes);
				end
				tw_d = it_q.word;
				tn_d = it_q.nbytes;
				k_d = 2'd0;
				jstep_d = 2'd0;
				state_d = S_ISSUE;
			end
			S_ISSUE: begin
				state_d = S_WAIT;
			end
			S_WAIT: begin
				if (mrsp.done) begin
					state_d = S_ISSUE;
					jstep_d = jstep_q + 2'd1;
					unique case (phase_q)
						PH_STRIPE: begin
							if (jstep_q == 2'd0) begin
								t_d = rotl64(acc_sel + p, 31);
							end else begin
								jstep_d = 2'd0;
								acc_d[{lane_q, k_q}] = p;
								if (k_q == 2'd3) begin
									k_d = 2'd0;
									if (lane_q) begin
										lane_d = 1'b0;
										seen_d = 1'b1;
										state_d = (it_q.kind == KIND_FINAL) ? S_START : S_IDLE;
									end else begin
										lane_d = 1'b1;
									end
								end else begin
									k_d = k_q + 2'd1;
								end
							end
						end
						PH_MERGE: begin
							if (jstep_q == 2'd0) begin
								t_d = rotl64(p, 31);
							end else if (jstep_q == 2'd1) begin
								t_d = h_q ^ p;
							end else begin
								jstep_d = 2'd0;
								if (k_q == 2'd3) begin
									h_d = p + P4 + it_q.len;
									k_d = 2'd0;
									phase_d = pick_phase(2'd0, it_q.nwords, tn_q);
								end else begin
									h_d = p + P4;
									k_d = k_q + 2'd1;
								end
							end
						end
						PH_WORDS, PH_TAIL8: begin
							if (jstep_q == 2'd0) begin
								t_d = rotl64(p, 31);
							end else if (jstep_q == 2'd1) begin
								h_d = h_q ^ p;
							end else begin
								jstep_d = 2'd0;
								h_d = p + P4;
								if (phase_q == PH_WORDS) begin
									k_d = k_q + 2'd1;
									phase_d = pick_phase(k_q + 2'd1, it_q.nwords, tn_q);
								end else begin
									phase_d = PH_AVAL;
								end
							end
						end
						PH_TAIL4: begin
							if (jstep_q == 2'd0) begin
								h_d = h_q ^ p;
							end else begin
								jstep_d = 2'd0;
								h_d = p + P3;
								tw_d = tw_q >> 32;
								tn_d = tn_q - 4'd4;
								phase_d = (tn_q != 4'd4) ? PH_TAIL1 : PH_AVAL;
							end
						end
						PH_TAIL1: begin
							if (jstep_q == 2'd0) begin
								h_d = h_q ^ p;
							end else begin
								jstep_d = 2'd0;
								h_d = p;
								tw_d = tw_q >> 8;
								tn_d = tn_q - 4'd1;
								phase_d = (tn_q != 4'd1) ? PH_TAIL1 : PH_AVAL;
							end
						end
						PH_AVAL: begin
							if (jstep_q == 2'd0) begin
								h_d = p;
							end else begin
								jstep_d = 2'd0;
								h_d = p ^ (p >> 32);
								if (!lane_q) begin
									dig0_d = p ^ (p >> 32);
									lane_d = 1'b1;
									state_d = S_START;
								end else begin
									state_d = S_OUT;
								end
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_OUT: begin
				if (!ovalid_q || digest_ready) begin
					ovalid_d = 1'b1;
					dlow_d = dig0_q;
					dhigh_d = h_q;
					seen_d = 1'b0;
					lane_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign digest_valid = ovalid_q;
	assign digest_low = dlow_q;
	assign digest_high = dhigh_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_STRIPE;
			jstep_q <= 2'd0;
			k_q <= 2'd0;
			lane_q <= 1'b0;
			seen_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			jstep_q <= jstep_d;
			k_q <= k_d;
			lane_q <= lane_d;
			seen_q <= seen_d;
			ovalid_q <= ovalid_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		acc_q <= acc_d;
		pw_q <= pw_d;
		it_q <= it_d;
		h_q <= h_d;
		t_q <= t_d;
		tw_q <= tw_d;
		tn_q <= tn_d;
		dig0_q <= dig0_d;
		dlow_q <= dlow_d;
		dhigh_q <= dhigh_d;
	end

endmodule

>>> hdl/dual_seed_xxhash64_engine.sv
// Dual-seed xxhash64 engine: two digests of one word stream, one result per last word.
// Front end accepts a word whenever the two-entry queue has room.
// A buffered word is stored by the back end without a multiply; each multiply job goes through the 3-step multiplier.
// Stripe-completing and last words are worked through the shared multiplier, which serves both
// seed lanes one after the other; for a last word the work also grows with the tail length.
// arst_n clears control state; seeds reset to 0 and P1, accumulators load on the first stripe.
module dual_seed_xxhash64_engine import dsxe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready,
	input logic word_valid,
	output logic word_ready,
	input logic [63:0] data_word,
	input logic [3:0] valid_bytes,
	input logic last,
	output logic digest_valid,
	input logic digest_ready,
	output logic [63:0] digest_low,
	output logic [63:0] digest_high
);

	logic [63:0] seed_low_q;
	logic [63:0] seed_high_q;
	logic push;
	logic full;
	logic pop;
	logic not_empty;
	item_t f_item;
	item_t q_item;
	mul_req_t mreq;
	mul_rsp_t mrsp;

	// configuration registers
	assign pready = 1'b1;
	assign prdata = (paddr[3] == REG_SEED_HIGH) ? seed_high_q : seed_low_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q <= 64'd0;
			seed_high_q <= P1;
		end else if (psel && penable && pwrite) begin
			if (paddr[3] == REG_SEED_HIGH) begin
				seed_high_q <= pwdata;
			end else begin
				seed_low_q <= pwdata;
			end
		end
	end

	dsxe_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.word_valid(word_valid),
		.word_ready(word_ready),
		.data_word(data_word),
		.valid_bytes(valid_bytes),
		.last(last),
		.full(full),
		.push(push),
		.item(f_item)
	);

	dsxe_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(f_item),
		.full(full),
		.pop(pop),
		.not_empty(not_empty),
		.dout(q_item)
	);

	dsxe_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.rsp(mrsp)
	);

	dsxe_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.seed_low(seed_low_q),
		.seed_high(seed_high_q),
		.q_valid(not_empty),
		.q_item(q_item),
		.q_pop(pop),
		.mreq(mreq),
		.mrsp(mrsp),
		.digest_valid(digest_valid),
		.digest_ready(digest_ready),
		.digest_low(digest_low),
		.digest_high(digest_high)
	);

endmodule

>>> hdl/dsxe_checker.sv
// port-level checker for the dual-seed xxhash64 engine and its bind
`include "dual_seed_xxhash64_engine_assert.svh"

module dsxe_checker import dsxe_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [63:0] pwdata,
	input logic [63:0] prdata,
	input logic pready,
	input logic digest_valid,
	input logic digest_ready,
	input logic [63:0] digest_low,
	input logic [63:0] digest_high
);

	// a stalled result stays offered
	`DSXE_ASSERT_NEXT(a_out_hold, digest_valid && !digest_ready, digest_valid, "result dropped while stalled")

	// a stalled result keeps both digests
	`DSXE_ASSERT_NEXT(a_out_stable, digest_valid && !digest_ready, $stable(digest_low) && $stable(digest_high), "result changed while stalled")

	// seed low reads back what was written
	`DSXE_ASSERT_NEXT(a_seed_low_rb, psel && penable && pwrite && pready && (paddr[3] == REG_SEED_LOW), (paddr[3] != REG_SEED_LOW) || (prdata == $past(pwdata)), "seed low readback mismatch")

	// seed high reads back what was written
	`DSXE_ASSERT_NEXT(a_seed_high_rb, psel && penable && pwrite && pready && (paddr[3] == REG_SEED_HIGH), (paddr[3] != REG_SEED_HIGH) || (prdata == $past(pwdata)), "seed high readback mismatch")

endmodule

bind dual_seed_xxhash64_engine dsxe_checker u_dsxe_checker (.*);

>>> dv/tb_dual_seed_xxhash64_engine.sv
// testbench for the dual-seed xxhash64 engine: predicted digests checked against the block
`timescale 1ns / 1ps
module tb_dual_seed_xxhash64_engine;
	import dsxe_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;
	logic word_valid, word_ready;
	logic [63:0] data_word;
	logic [3:0] valid_bytes;
	logic last;
	logic digest_valid, digest_ready;
	logic [63:0] digest_low, digest_high;

	dual_seed_xxhash64_engine uut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.word_valid(word_valid), .word_ready(word_ready), .data_word(data_word),
		.valid_bytes(valid_bytes), .last(last), .digest_valid(digest_valid),
		.digest_ready(digest_ready), .digest_low(digest_low), .digest_high(digest_high)
	);

	// predictor state
	logic [63:0] mdl_seed [2];
	logic [63:0] mdl_acc [8];
	logic [63:0] mdl_pend [3];
	int unsigned mdl_pcnt;
	logic [63:0] mdl_len;
	bit mdl_striped;

	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
	} digest_pair_t;
	digest_pair_t expected_digests [$];

	int errors = 0;
	longint unsigned cycle_count = 0;
	bit hold_off = 0;
	int hold_cycles = 0;
	bit gaps_on = 1;

	function automatic logic [63:0] rot(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic logic [63:0] mix(input logic [63:0] acc, input logic [63:0] v);
		logic [63:0] a;
		a = acc + v * P2;
		a = rot(a, 31);
		return a * P1;
	endfunction

	function automatic logic [63:0] fold_lane(input int ln, input int nw,
			input logic [63:0] part, input int n);
		logic [63:0] h;
		if (mdl_striped) begin
			h = rot(mdl_acc[4*ln], 1) + rot(mdl_acc[4*ln+1], 7) + rot(mdl_acc[4*ln+2], 12)
				+ rot(mdl_acc[4*ln+3], 18);
			for (int k = 0; k < 4; k++) begin
				h ^= mix(64'd0, mdl_acc[4*ln+k]);
				h = h * P1 + P4;
			end
		end else begin
			h = mdl_seed[ln] + P5;
		end
		h += mdl_len;
		for (int k = 0; k < nw; k++) begin
			h ^= mix(64'd0, mdl_pend[k]);
			h = rot(h, 27) * P1 + P4;
		end
		if (n >= 8) begin
			h ^= mix(64'd0, part);
			h = rot(h, 27) * P1 + P4;
		end else begin
			if (n >= 4) begin
				h ^= {32'd0, part[31:0]} * P1;
				h = rot(h, 23) * P2 + P3;
				part = part >> 32;
				n -= 4;
			end
			while (n > 0) begin
				h ^= {56'd0, part[7:0]} * P5;
				h = rot(h, 11) * P1;
				part = part >> 8;
				n--;
			end
		end
		h ^= h >> 33;
		h *= P2;
		h ^= h >> 29;
		h *= P3;
		h ^= h >> 32;
		return h;
	endfunction

	task automatic absorb_stripe(input logic [63:0] w3);
		logic [63:0] v;
		if (!mdl_striped) begin
			for (int ln = 0; ln < 2; ln++) begin
				mdl_acc[4*ln] = mdl_seed[ln] + P1 + P2;
				mdl_acc[4*ln+1] = mdl_seed[ln] + P2;
				mdl_acc[4*ln+2] = mdl_seed[ln];
				mdl_acc[4*ln+3] = mdl_seed[ln] - P1;
			end
			mdl_striped = 1;
		end
		for (int ln = 0; ln < 2; ln++)
			for (int k = 0; k < 4; k++) begin
				v = (k < 3) ? mdl_pend[k] : w3;
				mdl_acc[4*ln+k] = mix(mdl_acc[4*ln+k], v);
			end
	endtask

	task automatic predict_word(input logic [63:0] w, input logic [3:0] vb, input logic lst);
		int n;
		int nw;
		digest_pair_t d;
		if (!lst) begin
			mdl_len += 8;
			if (mdl_pcnt >= 3) begin
				absorb_stripe(w);
				mdl_pcnt = 0;
			end else begin
				mdl_pend[mdl_pcnt] = w;
				mdl_pcnt++;
			end
			return;
		end
		n = (vb > 8) ? 8 : vb;
		mdl_len += n;
		if (n < 8)
			w &= (64'd1 << (8 * n)) - 64'd1;
		if (n == 8 && mdl_pcnt >= 3) begin
			absorb_stripe(w);
			nw = 0;
			n = 0;
			w = 0;
		end else begin
			nw = mdl_pcnt;
		end
		d.lo = fold_lane(0, nw, w, n);
		d.hi = fold_lane(1, nw, w, n);
		expected_digests.push_back(d);
		mdl_pcnt = 0;
		mdl_len = 0;
		mdl_striped = 0;
	endtask

	// clock and watchdog
	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 64'd3000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// long receiver stall counted in cycles
	always @(negedge clk) begin
		if (hold_cycles > 0)
			hold_cycles <= hold_cycles - 1;
	end

	// receiver ready with random gaps
	always @(negedge clk) begin
		if (!arst_n || hold_off || hold_cycles > 0)
			digest_ready <= 0;
		else if (!gaps_on)
			digest_ready <= 1;
		else if ($urandom_range(0, 99) < 4)
			digest_ready <= 0;
		else
			digest_ready <= ($urandom_range(0, 3) != 0);
	end

	// result checker
	always @(posedge clk) begin
		digest_pair_t d;
		if (arst_n && digest_valid && digest_ready) begin
			if (expected_digests.size() == 0) begin
				$error("unexpected digest lo=%h hi=%h", digest_low, digest_high);
				errors++;
			end else begin
				d = expected_digests.pop_front();
				if (digest_low !== d.lo) begin
					$error("digest_low expected %h actual %h", d.lo, digest_low);
					errors++;
				end
				if (digest_high !== d.hi) begin
					$error("digest_high expected %h actual %h", d.hi, digest_high);
					errors++;
				end
			end
		end
	end

	task automatic write_seed(input logic idx, input logic [63:0] val);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		mdl_seed[idx] = val;
	endtask

	// drive one item; valid stays high across back-to-back items
	task automatic send_word(input logic [63:0] w, input logic [3:0] vb, input logic lst);
		int gap;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
			@(negedge clk);
			word_valid <= 0;
			repeat (gap) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		word_valid <= 1;
		data_word <= w;
		valid_bytes <= vb;
		last <= lst;
		predict_word(w, vb, lst);
		do @(posedge clk); while (!word_ready);
	endtask

	task automatic idle_sender;
		@(negedge clk);
		word_valid <= 0;
	endtask

	function automatic logic [63:0] rand64;
		return {$urandom, $urandom};
	endfunction

	// a message of nfull full words, then a last word with lb bytes
	task automatic send_message(input int nfull, input logic [3:0] lb, input int pat);
		logic [63:0] w;
		for (int i = 0; i < nfull; i++) begin
			w = (pat == 1) ? 64'd0 : (pat == 2) ? '1 : rand64();
			send_word(w, (pat == 3) ? 4'($urandom_range(0, 15)) : 4'd8, 0);
		end
		w = (pat == 1) ? 64'd0 : (pat == 2) ? '1 : rand64();
		send_word(w, lb, 1);
	endtask

	task automatic drain;
		idle_sender();
		while (expected_digests.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	task automatic test_directed;
		send_message(0, 4'd0, 1);
		send_message(0, 4'd8, 2);
		send_message(0, 4'd3, 0);
		send_message(0, 4'd5, 2);
		send_message(2, 4'd15, 0);
		send_message(3, 4'd8, 0);
		send_message(3, 4'd0, 2);
		send_message(4, 4'd7, 3);
		send_message(7, 4'd4, 0);
		drain();
	endtask

	task automatic test_seed_extremes;
		write_seed(REG_SEED_LOW, '1);
		write_seed(REG_SEED_HIGH, 64'd0);
		send_message(0, 4'd1, 0);
		send_message(5, 4'd6, 2);
		drain();
		write_seed(REG_SEED_LOW, 64'd1);
		write_seed(REG_SEED_HIGH, 64'h8000_0000_0000_0000);
		send_message(3, 4'd2, 0);
		send_message(8, 4'd8, 0);
		drain();
	endtask

	task automatic test_backpressure;
		hold_cycles = 3000;
		for (int m = 0; m < 8; m++)
			send_message($urandom_range(0, 6), 4'($urandom_range(0, 8)), 0);
		drain();
	endtask

	task automatic test_random;
		int sent;
		int nfull;
		int next_cfg;
		sent = 0;
		next_cfg = 0;
		while (sent < 1650) begin
			// new seeds every 400 items, one stretch without gaps
			if (sent >= next_cfg) begin
				drain();
				write_seed(REG_SEED_LOW, rand64());
				write_seed(REG_SEED_HIGH, rand64());
				gaps_on = (next_cfg != 800);
				next_cfg += 400;
			end
			nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
			send_message(nfull, 4'($urandom_range(0, 15)),
				($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
			sent += nfull + 1;
		end
		gaps_on = 1;
		drain();
	endtask

	initial begin
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		word_valid = 0;
		data_word = '0;
		valid_bytes = '0;
		last = 0;
		digest_ready = 0;
		mdl_seed[0] = 64'd0;
		mdl_seed[1] = P1;
		mdl_pcnt = 0;
		mdl_len = 0;
		mdl_striped = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		test_directed();
		test_seed_extremes();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

>>> sim.f
+incdir+hdl
hdl/dsxe_pkg.sv
hdl/dsxe_front.sv
hdl/dsxe_fifo.sv
hdl/dsxe_mul.sv
hdl/dsxe_back.sv
hdl/dual_seed_xxhash64_engine.sv
hdl/dsxe_checker.sv
dv/tb_dual_seed_xxhash64_engine.sv
